### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clk edge outside reset.
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clk edge outside reset.
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sfr_pkg.sv
// Package: shared constants, types and helpers of the serial frame receiver.
package sfr_pkg;

  localparam int PAYLOAD_BYTES = 4;
  localparam int PACKED_BYTES  = (PAYLOAD_BYTES < 4) ? PAYLOAD_BYTES : 4;
  localparam int CNT_W         = 3;

  localparam logic [7:0] HEADER_BYTE     = 8'hAA;
  localparam logic [7:0] SECOND_ACK_BYTE = 8'hBB;
  localparam logic [7:0] FILL_ACK_BYTE   = 8'h00;

  localparam int ACK_RUN_LENGTH = 7;
  localparam int ACK_IDX_W      = $clog2(ACK_RUN_LENGTH);
  localparam logic [ACK_IDX_W-1:0] ACK_LAST_IDX = ACK_IDX_W'(ACK_RUN_LENGTH - 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_HUNT     = 2'd0,
    PH_COMMAND  = 2'd1,
    PH_PAYLOAD  = 2'd2,
    PH_CHECKSUM = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]  command;
    logic [31:0] payload;
  } frame_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [7:0] ack_byte_at(input logic [ACK_IDX_W-1:0] idx);
    logic [7:0] val;
    case (idx)
      ACK_IDX_W'(0): val = HEADER_BYTE;
      ACK_IDX_W'(1): val = SECOND_ACK_BYTE;
      default:       val = FILL_ACK_BYTE;
    endcase
    return val;
  endfunction

endpackage

### hw/rtl/sfr_front.sv
// Front end: frame parser with running checksum; pushes good frames to the queue.
module sfr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      rx_byte,
  output logic            push,
  output sfr_pkg::frame_t push_frame
);
  import sfr_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       held_r [PACKED_BYTES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cnt_r   <= '0;
      sum_r   <= '0;
      cmd_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  // Payload slots: each written only at its own count.
  always_ff @(posedge clk) begin
    for (int i = 0; i < PACKED_BYTES; i++) begin
      if (take && phase_r == PH_PAYLOAD && cnt_r == CNT_W'(i)) begin
        held_r[i] <= rx_byte;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    cmd_nxt   = cmd_r;
    push      = 1'b0;
    if (take) begin
      case (phase_r)
        PH_HUNT: begin
          if (rx_byte == HEADER_BYTE) begin
            sum_nxt   = rx_byte;
            cnt_nxt   = '0;
            phase_nxt = PH_COMMAND;
          end
        end
        PH_COMMAND: begin
          cmd_nxt   = rx_byte;
          sum_nxt   = sum_r + rx_byte;
          cnt_nxt   = '0;
          phase_nxt = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum_nxt = sum_r + rx_byte;
          if (cnt_r == CNT_W'(PAYLOAD_BYTES - 1)) begin
            cnt_nxt   = '0;
            phase_nxt = PH_CHECKSUM;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        default: begin
          push      = (sum_r == rx_byte);
          cnt_nxt   = '0;
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  // Pack the held payload, first byte low; unused upper bytes read zero.
  always_comb begin
    push_frame.command = cmd_r;
    push_frame.payload = '0;
    for (int i = 0; i < PACKED_BYTES; i++) begin
      push_frame.payload[8*i +: 8] = held_r[i];
    end
  end

endmodule

### hw/rtl/sfr_queue.sv
// Frame queue: small FIFO of accepted frames between parser and acknowledge sequencer.
module sfr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sfr_pkg::frame_t  push_frame,
  input  logic             pop,
  output sfr_pkg::frame_t  head_frame,
  output sfr_pkg::q_stat_t stat
);
  import sfr_pkg::*;

  frame_t            slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_frame;
  end

  assign head_frame = slot_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));

endmodule

### hw/rtl/sfr_back.sv
// Back end: plays out the seven-beat acknowledge run for each queued frame.
module sfr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  sfr_pkg::frame_t  head_frame,
  input  sfr_pkg::q_stat_t stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_ack_byte,
  output logic             out_last_of_run,
  output logic [7:0]       out_frame_command,
  output logic [31:0]      out_frame_payload
);
  import sfr_pkg::*;

  logic                 active_r, active_nxt;
  logic [ACK_IDX_W-1:0] idx_r, idx_nxt;
  frame_t               rec_r;
  logic                 beat_done, at_last, want_load;

  assign beat_done = active_r && !out_stall;
  assign at_last   = (idx_r == ACK_LAST_IDX);
  assign want_load = !active_r || (beat_done && at_last);
  assign pop       = want_load && !stat.empty;

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (pop) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
    end else if (beat_done) begin
      if (at_last) begin
        active_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + ACK_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) rec_r <= head_frame;
  end

  assign out_valid         = active_r;
  assign out_ack_byte      = ack_byte_at(idx_r);
  assign out_last_of_run   = at_last;
  assign out_frame_command = rec_r.command;
  assign out_frame_payload = rec_r.payload;

endmodule

### hw/rtl/serial_frame_receiver_checksum.sv
// Top level: serial frame receiver with additive checksum and acknowledge run.
// Path: after a frame's checksum beat is accepted, its first ack beat shows
//   once the queue is written and the back end loads it, when the back end is idle.
// Throughput: one byte in per cycle unless the queue is full; seven output beats
//   per good frame, one per cycle if unstalled, bounded by the single ack sequencer.
// Reset: synchronous, active-low rst_n; parser returns to header hunt, queue empties.
module serial_frame_receiver_checksum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_ack_byte,
  output logic        out_last_of_run,
  output logic [7:0]  out_frame_command,
  output logic [31:0] out_frame_payload
);
  import sfr_pkg::*;

  // Front end parses one byte per beat; it only ever pushes on the checksum
  // beat, so holding the input while the queue is full is enough back-pressure.
  logic    take;
  logic    push;
  logic    pop;
  frame_t  push_frame;
  frame_t  head_frame;
  q_stat_t stat;

  assign in_stall = stat.full;
  assign take     = in_valid && !in_stall;

  // Parse header, command, payload and checksum; emit a frame on a match.
  sfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .rx_byte    (in_rx_byte),
    .push       (push),
    .push_frame (push_frame)
  );

  // Decouple parsing from the slower acknowledge playback.
  sfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head_frame (head_frame),
    .stat       (stat)
  );

  // Drive the acknowledge run AA BB 00 00 00 00 00 for each frame.
  sfr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_frame        (head_frame),
    .stat              (stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ack_byte      (out_ack_byte),
    .out_last_of_run   (out_last_of_run),
    .out_frame_command (out_frame_command),
    .out_frame_payload (out_frame_payload)
  );

endmodule

### hw/rtl/sfr_checker.sv
// Checker: port-level properties of the serial frame receiver, bound to the top level.
`include "assert_macros.svh"

module sfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_ack_byte,
  input logic        out_last_of_run,
  input logic [7:0]  out_frame_command,
  input logic [31:0] out_frame_payload
);
  import sfr_pkg::*;

  // Hold the beat while stalled.
  `SFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_ack_byte) && $stable(out_last_of_run) && $stable(out_frame_command) && $stable(out_frame_payload), "stalled output beat changed")

  // Advance through a run without gaps.
  `SFR_ASSERT_NEXT(a_run_gapless, out_valid && !out_stall && !out_last_of_run, out_valid, "gap inside acknowledge run")

  // A new run opens with the header byte.
  `SFR_ASSERT_NEXT(a_run_opens, out_valid && !out_stall && out_last_of_run, !out_valid || out_ack_byte == HEADER_BYTE, "acknowledge run did not open with header byte")

  // The opening byte is never the closing beat.
  `SFR_ASSERT_NOW(a_open_not_last, out_valid && out_ack_byte == HEADER_BYTE, !out_last_of_run, "header byte flagged as last of run")

endmodule

bind serial_frame_receiver_checksum sfr_checker u_sfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_ack_byte      (out_ack_byte),
  .out_last_of_run   (out_last_of_run),
  .out_frame_command (out_frame_command),
  .out_frame_payload (out_frame_payload)
);
